FILE: rtl/core/bidalloc_pkg.sv
// Shared constants and types for the bitmap id allocator.
package bidalloc_pkg;

    localparam int TotalEntries = 256;
    localparam int IdxW         = 8;
    localparam int SizeW        = 9;
    localparam int TagW         = 24;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_REINIT = 2'd2;
    localparam logic [1:0] CMD_BAD    = 2'd3;

    localparam logic [1:0] REG_TOP_RSV         = 2'd0;
    localparam logic [1:0] REG_RESERVED_BOTTOM = 2'd1;
    localparam logic [1:0] REG_TAG_MASK        = 2'd2;

    // map operation requested by the sequencer for one slot
    typedef enum logic [1:0] {
        MAP_NONE,
        MAP_SET,
        MAP_CLR
    } map_op_t;

    typedef struct packed {
        map_op_t          op;
        logic [IdxW-1:0]  addr;
    } map_ctrl_t;

endpackage

FILE: rtl/core/bitmap_id_allocator_unit.sv
// Top level of the bitmap id allocator: command sequencer and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, count, alignment,
//   object_in and keep_cursor. Output channel (out_valid/out_ready) carries
//   status and object_id, one result per command.
//   Configuration registers (top reserve, bottom reserve, tag mask) are
//   written through cfg_we/cfg_index/cfg_data while the block is idle.
//   One command at a time; in_ready is low while it works and while a result
//   waits to be taken.
//   Map access: the map is a RAM with a registered probe, so the search waits
//   for the probe data of each slot it looks at. Allocate searches from the
//   cursor and restarts once from zero if that pass finds no area; each pass
//   visits a usable slot at most once. Free clears at most count slots (only
//   those below the usable limit), reinitialize rewrites every map entry,
//   and an unknown command only returns a failed status.
//   Reset clears the cursor, the tag and the registers, then runs a clearing
//   pass over all map entries with in_ready low.
//   A stalled receiver holds the result; no new command is taken until the
//   result transfer completes.
module bitmap_id_allocator_unit
    import bidalloc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [8:0]        count,
    input  logic [8:0]        alignment,
    input  logic [23:0]       object_in,
    input  logic              keep_cursor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [23:0]       object_id,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SKIP,
        S_CHECK,
        S_RETRY,
        S_MARK,
        S_FREE,
        S_INIT,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [7:0]          rtop_reg, rbot_reg;
    logic [TagW-1:0]     tmask_reg, tag_reg;
    logic [IdxW-1:0]     cursor_reg;
    logic [SizeW-1:0]    size_reg;     // usable slots
    logic [SizeW-1:0]    cnt_reg;      // count, 1..511
    logic [IdxW-1:0]     amask_reg;
    logic [SizeW-1:0]    pos_reg;      // scan position
    logic [SizeW-1:0]    start_reg;    // candidate area start
    logic [SizeW-1:0]    k_reg;        // slots done in current pass
    logic [SizeW-1:0]    fill_reg;     // entries below this are set by the init pass
    logic                second_reg;   // searching from zero after tag advance
    logic                keep_reg;
    logic                look_reg;     // probe data for the current address is ready
    logic                boot_reg;     // clearing pass after reset, no result
    logic                out_valid_reg, status_reg;
    logic [TagW-1:0]     id_reg;

    map_ctrl_t           mctl;
    logic [IdxW-1:0]     probe_addr;
    logic                probe_used;

    logic [SizeW-1:0]    usable;
    logic [SizeW-1:0]    cnt_in;
    logic [IdxW-1:0]     amask_in;
    logic [SizeW-1:0]    aligned;
    logic [SizeW:0]      endpos;
    logic [SizeW-1:0]    chk;
    logic [TagW-1:0]     tag_adv;

    assign usable  = (rtop_reg == 8'd0) ? SizeW'(TotalEntries)
                                        : SizeW'(TotalEntries) - SizeW'(rtop_reg);
    assign cnt_in  = (count == 9'd0) ? 9'd1 : count;
    assign aligned = (pos_reg + SizeW'(amask_reg)) & ~SizeW'(amask_reg);
    assign endpos  = {1'b0, aligned} + {1'b0, cnt_reg};
    assign chk     = start_reg + k_reg;
    assign tag_adv = (tag_reg + TagW'(TotalEntries)) & tmask_reg;

    // round alignment down to a power of two, minus one
    always_comb
    begin
        amask_in = '0;
        for (int b = 8; b >= 0; b--)
        begin
            if (alignment[b] && amask_in == '0)
            begin
                amask_in = IdxW'((9'd1 << b) - 9'd1);
            end
        end
    end

    always_comb
    begin
        probe_addr = pos_reg[IdxW-1:0];
        if (state_reg == S_CHECK)
        begin
            probe_addr = chk[IdxW-1:0];
        end
    end

    bidalloc_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mctl),
        .probe_addr (probe_addr),
        .probe_used (probe_used)
    );

    always_comb
    begin
        mctl.op   = MAP_NONE;
        mctl.addr = chk[IdxW-1:0];
        unique case (state_reg)
            S_MARK:
            begin
                mctl.op = MAP_SET;
            end
            S_FREE:
            begin
                if (chk < size_reg && k_reg < cnt_reg)
                begin
                    mctl.op = MAP_CLR;
                end
            end
            S_INIT:
            begin
                mctl.addr = pos_reg[IdxW-1:0];
                mctl.op   = (pos_reg < fill_reg) ? MAP_SET : MAP_CLR;
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign object_id = id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rtop_reg      <= '0;
            rbot_reg      <= '0;
            tmask_reg     <= '0;
            tag_reg       <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
            id_reg        <= '0;
            size_reg      <= '0;
            cnt_reg       <= '0;
            amask_reg     <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            k_reg         <= '0;
            fill_reg      <= '0;
            second_reg    <= 1'b0;
            keep_reg      <= 1'b0;
            look_reg      <= 1'b0;
            boot_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TOP_RSV:         rtop_reg  <= cfg_data[7:0];
                    REG_RESERVED_BOTTOM: rbot_reg  <= cfg_data[7:0];
                    REG_TAG_MASK:        tmask_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        size_reg   <= usable;
                        cnt_reg    <= cnt_in;
                        amask_reg  <= amask_in;
                        keep_reg   <= keep_cursor;
                        k_reg      <= '0;
                        second_reg <= 1'b0;
                        look_reg   <= 1'b0;
                        status_reg <= 1'b0;
                        id_reg     <= '0;
                        unique case (command)
                            CMD_ALLOC:
                            begin
                                pos_reg   <= SizeW'(cursor_reg);
                                state_reg <= S_SKIP;
                            end
                            CMD_FREE:
                            begin
                                start_reg <= SizeW'(object_in[IdxW-1:0]);
                                state_reg <= S_FREE;
                            end
                            CMD_REINIT:
                            begin
                                pos_reg    <= '0;
                                fill_reg   <= (SizeW'(rbot_reg) < usable) ? SizeW'(rbot_reg)
                                                                          : usable;
                                cursor_reg <= '0;
                                tag_reg    <= '0;
                                state_reg  <= S_INIT;
                            end
                            default:
                            begin
                                status_reg <= 1'b1;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SKIP:
                begin
                    // walk past used slots, then align and bound the area
                    if (pos_reg >= size_reg)
                    begin
                        state_reg <= S_RETRY;
                    end
                    else if (!look_reg)
                    begin
                        look_reg <= 1'b1;
                    end
                    else
                    begin
                        look_reg <= 1'b0;
                        if (probe_used)
                        begin
                            pos_reg <= pos_reg + 9'd1;
                        end
                        else if (endpos > {1'b0, size_reg} || aligned < pos_reg)
                        begin
                            state_reg <= S_RETRY;
                        end
                        else
                        begin
                            start_reg <= aligned;
                            k_reg     <= '0;
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                begin
                    if (k_reg == cnt_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MARK;
                    end
                    else if (!look_reg)
                    begin
                        look_reg <= 1'b1;
                    end
                    else
                    begin
                        look_reg <= 1'b0;
                        if (probe_used)
                        begin
                            pos_reg   <= chk + 9'd1;
                            state_reg <= S_SKIP;
                        end
                        else
                        begin
                            k_reg <= k_reg + 9'd1;
                        end
                    end
                end
                S_RETRY:
                begin
                    if (second_reg)
                    begin
                        status_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        tag_reg    <= tag_adv;
                        second_reg <= 1'b1;
                        pos_reg    <= '0;
                        state_reg  <= S_SKIP;
                    end
                end
                S_MARK:
                begin
                    if (k_reg + 9'd1 == cnt_reg)
                    begin
                        if ((cnt_reg == 9'd1 && amask_reg == '0)
                            || start_reg == SizeW'(cursor_reg))
                        begin
                            if (start_reg + cnt_reg >= size_reg)
                            begin
                                cursor_reg <= '0;
                            end
                            else
                            begin
                                cursor_reg <= IdxW'(start_reg + cnt_reg);
                            end
                        end
                        id_reg    <= TagW'(start_reg[IdxW-1:0]) | tag_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 9'd1;
                    end
                end
                S_FREE:
                begin
                    if (k_reg >= cnt_reg || chk >= size_reg)
                    begin
                        if (!keep_reg && start_reg < SizeW'(cursor_reg))
                        begin
                            cursor_reg <= start_reg[IdxW-1:0];
                        end
                        tag_reg   <= tag_adv;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 9'd1;
                    end
                end
                S_INIT:
                begin
                    // rewrite every map entry; the pass after reset gives no result
                    if (pos_reg == SizeW'(TotalEntries - 1))
                    begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? S_IDLE : S_DONE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 9'd1;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result missing after command");
    a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (object_id == '0))
        else $error("failed command returned an id");
`endif

endmodule

FILE: rtl/core/bidalloc_map.sv
// Used-slot bitmap RAM: one registered probe and one write per cycle.
module bidalloc_map
    import bidalloc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  map_ctrl_t                ctrl,
    input  logic [IdxW-1:0]          probe_addr,
    output logic                     probe_used
);

    logic                    used_mem [TotalEntries];
    logic                    probe_reg;

    assign probe_used = probe_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            MAP_SET: used_mem[ctrl.addr] <= 1'b1;
            MAP_CLR: used_mem[ctrl.addr] <= 1'b0;
            default: ;
        endcase
    end

    // probe data is valid the cycle after the address is presented
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= 1'b0;
        end
        else
        begin
            probe_reg <= used_mem[probe_addr];
        end
    end

endmodule

FILE: tb/sv/bidalloc_checker.sv
// Checker for the bitmap id allocator: watches both channels, predicts and compares.
module bidalloc_checker
    import bidalloc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [8:0]  count,
    input  logic [8:0]  alignment,
    input  logic [23:0] object_in,
    input  logic        keep_cursor,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        status,
    input  logic [23:0] object_id,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          n_results
);

    typedef struct packed {
        logic        st;
        logic [23:0] id;
    } alloc_result_t;

    logic [TotalEntries-1:0] slot_used;
    int unsigned             cursor;
    logic [23:0]             gen_tag;
    int unsigned             top_rsv;
    int unsigned             bot_rsv;
    logic [23:0]             tmask;
    alloc_result_t           result_q[$];

    assign pending = result_q.size();

    function automatic int unsigned usable();
        return (top_rsv >= TotalEntries) ? 0 : TotalEntries - top_rsv;
    endfunction

    function automatic void bump_tag();
        gen_tag = (gen_tag + 24'(TotalEntries)) & tmask;
    endfunction

    function automatic void wipe_map();
        slot_used = '0;
        for (int unsigned i = 0; i < bot_rsv && i < usable(); i++)
            slot_used[i] = 1'b1;
        cursor  = 0;
        gen_tag = '0;
    endfunction

    // next-fit search; returns lim when no area fits
    function automatic int unsigned search_area(int unsigned from, int unsigned nr,
                                                int unsigned amask, int unsigned lim);
        int unsigned idx;
        int unsigned stop;
        int unsigned i;
        bit          hit;
        forever
        begin
            idx = from;
            hit = 0;
            while (idx < lim && slot_used[idx])
                idx++;
            if (idx >= lim)
                return lim;
            idx = (idx + amask) & ~amask;
            stop = idx + nr;
            if (stop > lim)
                return lim;
            for (i = idx; i < stop; i++)
            begin
                if (slot_used[i])
                begin
                    hit = 1;
                    break;
                end
            end
            if (!hit)
                return idx;
            from = i + 1;
        end
    endfunction

    function automatic alloc_result_t predict_command(logic [1:0] cmd, logic [8:0] cnt9,
                                                      logic [8:0] aln, logic [23:0] obj,
                                                      logic keep);
        alloc_result_t r;
        int unsigned   lim;
        int unsigned   cnt;
        int unsigned   a;
        int unsigned   idx;
        int unsigned   base;
        bit            single;
        r   = '0;
        lim = usable();
        cnt = (cnt9 == 0) ? 1 : cnt9;
        case (cmd)
            CMD_ALLOC:
            begin
                a = 1;
                while (aln != 0 && (a << 1) <= aln)
                    a = a << 1;
                single = (cnt == 1 && a == 1);
                idx = search_area(cursor, cnt, a - 1, lim);
                if (idx >= lim)
                begin
                    bump_tag();
                    idx = search_area(0, cnt, a - 1, lim);
                end
                if (idx < lim)
                begin
                    for (int unsigned i = 0; i < cnt; i++)
                        slot_used[idx + i] = 1'b1;
                    if (single || idx == cursor)
                    begin
                        cursor = idx + cnt;
                        if (cursor >= lim)
                            cursor = 0;
                    end
                    r.id = 24'(idx) | gen_tag;
                end
                else
                    r.st = 1'b1;
            end
            CMD_FREE:
            begin
                base = obj & (TotalEntries - 1);
                for (int unsigned i = 0; i < cnt; i++)
                    if (base + i < lim)
                        slot_used[base + i] = 1'b0;
                if (!keep && base < cursor)
                    cursor = base;
                bump_tag();
            end
            CMD_REINIT:
                wipe_map();
            default:
                r.st = 1'b1;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t exp_r;
        if (!rst_n)
        begin
            top_rsv   = 0;
            bot_rsv   = 0;
            tmask     = '0;
            wipe_map();
            result_q.delete();
            errors    = 0;
            n_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TOP_RSV)
                    top_rsv = cfg_data[7:0];
                else if (cfg_index == REG_RESERVED_BOTTOM)
                    bot_rsv = cfg_data[7:0];
                else if (cfg_index == REG_TAG_MASK)
                    tmask = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (result_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: status=%0d object_id=%0h",
                           status, object_id);
                    errors++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $error("status: expected %0d actual %0d", exp_r.st, status);
                        errors++;
                    end
                    if (object_id !== exp_r.id)
                    begin
                        $error("object_id: expected %0h actual %0h", exp_r.id, object_id);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(predict_command(command, count, alignment,
                                                   object_in, keep_cursor));
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the bitmap id allocator: stimulus, idling, pressure and verdict.
module tb_top
    import bidalloc_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [8:0]  count;
    logic [8:0]  alignment;
    logic [23:0] object_in;
    logic        keep_cursor;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic [23:0] object_id;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    int          errors;
    int          pending;
    int          n_results;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int          cycles;
    int          n_sent;
    logic [23:0] last_ids[$];

    bitmap_id_allocator_unit dut (.*);

    bidalloc_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit for ~1500 items; a hang ends the test as a mismatch
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 20000000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_used;
        out_ready = 1'b0;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send(logic [1:0] cmd, logic [8:0] cnt, logic [8:0] aln,
                        logic [23:0] obj, logic keep);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        count       <= cnt;
        alignment   <= aln;
        object_in   <= obj;
        keep_cursor <= keep;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic rand_item();
        int          pick;
        logic [8:0]  cnt;
        logic [8:0]  aln;
        logic [23:0] obj;
        pick = $urandom_range(99);
        cnt  = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(8));
        aln  = ($urandom_range(7) == 0) ? 9'($urandom) : 9'(1 << $urandom_range(3));
        if (last_ids.size() > 0 && $urandom_range(3) != 0)
            obj = last_ids[$urandom_range(last_ids.size() - 1)];
        else
            obj = 24'($urandom);
        if (pick < 55)
            send(CMD_ALLOC, cnt, aln, 24'($urandom), 1'($urandom));
        else if (pick < 93)
            send(CMD_FREE, cnt, aln, obj, 1'($urandom));
        else if (pick < 97)
            send(CMD_REINIT, cnt, aln, obj, 1'($urandom));
        else
            send(CMD_BAD, cnt, aln, obj, 1'($urandom));
        if (out_valid && object_id != 0)
            last_ids.push_back(object_id);
        if (last_ids.size() > 32)
            void'(last_ids.pop_front());
    endtask

    task automatic rand_phase(int n);
        for (int i = 0; i < n; i++)
            rand_item();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        count = '0;
        alignment = '0;
        object_in = '0;
        keep_cursor = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TOP_RSV;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        n_sent = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes and special cases
        write_reg(REG_TAG_MASK, 24'hFFFFFF);
        send(CMD_ALLOC, 9'd1, 9'd1, '0, 1'b0);
        send(CMD_ALLOC, 9'd0, 9'd0, '0, 1'b0);
        send(CMD_ALLOC, 9'd3, 9'd6, '0, 1'b0);
        send(CMD_ALLOC, 9'd256, 9'd256, '0, 1'b0);
        send(CMD_ALLOC, 9'd5, 9'd256, '0, 1'b0);
        send(CMD_FREE, 9'd0, 9'd0, 24'hFFFFFF, 1'b0);
        send(CMD_FREE, 9'd511, 9'd511, 24'h000102, 1'b1);
        send(CMD_ALLOC, 9'd16, 9'd511, '0, 1'b1);
        send(CMD_FREE, 9'd4, 9'd1, 24'h000000, 1'b0);
        send(CMD_ALLOC, 9'd1, 9'd1, '0, 1'b0);
        send(CMD_BAD, 9'h1FF, 9'h1FF, 24'hFFFFFF, 1'b1);
        send(CMD_REINIT, 9'd1, 9'd1, '0, 1'b0);
        send(CMD_ALLOC, 9'd300, 9'd1, '0, 1'b0);
        send(CMD_ALLOC, 9'd256, 9'd1, '0, 1'b0);
        send(CMD_ALLOC, 9'd1, 9'd1, '0, 1'b0);
        drain();
        write_reg(REG_TOP_RSV, 24'd255);
        write_reg(REG_RESERVED_BOTTOM, 24'd255);
        send(CMD_REINIT, 9'd1, 9'd1, '0, 1'b0);
        send(CMD_ALLOC, 9'd1, 9'd1, '0, 1'b0);
        send(CMD_FREE, 9'd2, 9'd1, 24'h0000FF, 1'b0);
        send(CMD_ALLOC, 9'd1, 9'd1, '0, 1'b0);
        drain();
        write_reg(REG_TOP_RSV, 24'd0);
        write_reg(REG_RESERVED_BOTTOM, 24'd0);
        send(CMD_ALLOC, 9'd1, 9'd1, '0, 1'b0);
        drain();

        // random: several register settings x three idling regimes
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_TOP_RSV, (phase == 1) ? 24'd255 :
                      (phase == 3) ? 24'd200 : 24'($urandom_range(64)));
            write_reg(REG_RESERVED_BOTTOM, (phase == 2) ? 24'd255 : 24'($urandom_range(40)));
            write_reg(REG_TAG_MASK, (phase == 0) ? 24'd0 : (phase == 4) ? 24'hFFFFFF
                      : 24'($urandom));
            send_idle_pct = (phase < 2) ? 38 : (phase < 4) ? 65 : 0;
            recv_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 38 : 0;
            if (phase == 4)
                hold_req = 1'b1;
            send(CMD_REINIT, 9'd1, 9'd1, '0, 1'b0);
            rand_phase(240);
        end

        // sender pauses until all results are in, then a burst
        drain();
        rand_phase(60);

        $display("covered %0d commands and %0d results over six register settings,",
                 n_sent, n_results);
        $display("with idling on both sides, a long receiver stall and a full drain");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
